>>> design/tgarle_pkg.sv
// Shared constants and types for the TGA run-length pixel decoder.
package tgarle_pkg;

  localparam int unsigned MAX_PIXEL_BYTES_DEF = 4;
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned DIM_W    = 16;
  localparam int unsigned AREA_W   = 32;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned GATHER_W = 24;

  localparam logic [BPP_W-1:0] BPP_RESET = 3'd3;
  localparam logic [DIM_W-1:0] DIM_RESET = 16'd1;

  localparam int unsigned RUN_FLAG_BIT = 7;
  localparam logic [6:0]  LENGTH_MASK  = 7'h7f;
  localparam int unsigned BYTE_BITS    = 8;

  typedef enum logic [1:0] {
    REG_BPP    = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               is_start;
    logic [PIXEL_W-1:0] pixel;
    logic [COUNT_W-1:0] count;
  } evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> design/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder with configuration registers.
// Throughput: one payload byte accepted every cycle while the result side keeps up.
// A completed pixel enters the queue at the edge that accepts its last byte, then the
// accounting stage loads the output register from the queue head once the output is free.
// Reset: awaits a packet header, 3 bytes per pixel, 1x1 image, queue and output empty.
// Image size is latched from the registered width*height product at each start mark.
module tga_rle_pixel_decoder #(
  parameter int unsigned MAX_PIXEL_BYTES = tgarle_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_start_mark,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tgarle_pkg::PIXEL_W-1:0]  out_pixel_value,
  output logic [tgarle_pkg::COUNT_W-1:0]  out_repeat_count,
  output logic                            out_image_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [tgarle_pkg::DIM_W-1:0]    cfg_data
);

  logic [tgarle_pkg::BPP_W-1:0]  bpp_r;
  logic [tgarle_pkg::DIM_W-1:0]  width_r;
  logic [tgarle_pkg::DIM_W-1:0]  height_r;
  logic [tgarle_pkg::AREA_W-1:0] area_r, area_nxt;
  logic                          cfg_we;

  logic                  push;
  logic                  pop;
  tgarle_pkg::evt_t      push_evt;
  tgarle_pkg::evt_t      head_evt;
  tgarle_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    area_nxt = area_r;
    if (cfg_we && cfg_index == tgarle_pkg::REG_WIDTH) begin
      area_nxt = tgarle_pkg::AREA_W'(cfg_data) * tgarle_pkg::AREA_W'(height_r);
    end else if (cfg_we && cfg_index == tgarle_pkg::REG_HEIGHT) begin
      area_nxt = tgarle_pkg::AREA_W'(width_r) * tgarle_pkg::AREA_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= tgarle_pkg::BPP_RESET;
      width_r  <= tgarle_pkg::DIM_RESET;
      height_r <= tgarle_pkg::DIM_RESET;
      area_r   <= tgarle_pkg::AREA_W'(1);
    end else begin
      area_r <= area_nxt;
      if (cfg_we && cfg_index == tgarle_pkg::REG_BPP) begin
        bpp_r <= cfg_data[tgarle_pkg::BPP_W-1:0];
      end
      if (cfg_we && cfg_index == tgarle_pkg::REG_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_we && cfg_index == tgarle_pkg::REG_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  tgarle_front #(
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_start_mark (in_start_mark),
    .bpp           (bpp_r),
    .q_status      (q_status),
    .push          (push),
    .push_evt      (push_evt)
  );

  tgarle_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head_evt (head_evt),
    .status   (q_status)
  );

  tgarle_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .head_evt         (head_evt),
    .pop              (pop),
    .area             (area_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_value  (out_pixel_value),
    .out_repeat_count (out_repeat_count),
    .out_image_done   (out_image_done)
  );

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_repeat_count != 8'd0 && out_repeat_count <= 8'd128))
    else $error("repeat count out of range");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("event pushed into a full queue");

  a_start_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_evt.is_start && out_valid && !out_ready) |=> out_valid)
    else $error("start event disturbed a pending result");

endmodule

>>> design/tgarle_front.sv
// Packet parser: header decode, pixel byte gathering and event generation.
module tgarle_front #(
  parameter int unsigned MAX_PIXEL_BYTES = tgarle_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_start_mark,
  input  logic [tgarle_pkg::BPP_W-1:0]  bpp,
  input  tgarle_pkg::q_status_t         q_status,
  output logic                          push,
  output tgarle_pkg::evt_t              push_evt
);

  logic                                expect_r, expect_nxt;
  logic                                run_r, run_nxt;
  logic [tgarle_pkg::COUNT_W-1:0]      left_r, left_nxt;
  logic [1:0]                          pos_r, pos_nxt;
  logic [tgarle_pkg::GATHER_W-1:0]     gather_r, gather_nxt;

  logic                                accept;
  logic                                hdr;
  logic [tgarle_pkg::BPP_W-1:0]        bpp_eff;
  logic [tgarle_pkg::BPP_W-1:0]        pos_inc;
  logic [tgarle_pkg::PIXEL_W-1:0]      byte_shifted;
  logic [tgarle_pkg::COUNT_W-1:0]      left_dec;
  logic                                pix_done;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign hdr      = in_start_mark || expect_r;

  always_comb begin
    priority if (bpp == '0) begin
      bpp_eff = tgarle_pkg::BPP_W'(1);
    end else if (bpp > tgarle_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = tgarle_pkg::BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp;
    end
  end

  assign pos_inc      = {1'b0, pos_r} + tgarle_pkg::BPP_W'(1);
  assign byte_shifted = {24'd0, in_data_byte} << {pos_r, 3'b000};
  assign left_dec     = (left_r != '0) ? left_r - 8'd1 : left_r;

  always_comb begin
    expect_nxt      = expect_r;
    run_nxt         = run_r;
    left_nxt        = left_r;
    pos_nxt         = pos_r;
    gather_nxt      = gather_r;
    pix_done        = 1'b0;
    push_evt.is_start = in_start_mark;
    push_evt.pixel    = {8'd0, gather_r} | byte_shifted;
    push_evt.count    = 8'd1;
    if (hdr) begin
      run_nxt    = in_data_byte[tgarle_pkg::RUN_FLAG_BIT];
      left_nxt   = {1'b0, in_data_byte[6:0] & tgarle_pkg::LENGTH_MASK} + 8'd1;
      expect_nxt = 1'b0;
      pos_nxt    = '0;
      gather_nxt = '0;
    end else if (pos_inc < bpp_eff) begin
      gather_nxt = gather_r | byte_shifted[tgarle_pkg::GATHER_W-1:0];
      pos_nxt    = pos_inc[1:0];
    end else begin
      pix_done   = 1'b1;
      pos_nxt    = '0;
      gather_nxt = '0;
      if (run_r) begin
        push_evt.count = (left_r == '0) ? 8'd1 : left_r;
        left_nxt       = '0;
        expect_nxt     = 1'b1;
      end else begin
        left_nxt   = left_dec;
        expect_nxt = (left_dec == '0);
      end
    end
  end

  assign push = accept && (in_start_mark || pix_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= 1'b1;
      run_r    <= 1'b0;
      left_r   <= '0;
      pos_r    <= '0;
      gather_r <= '0;
    end else if (accept) begin
      expect_r <= expect_nxt;
      run_r    <= run_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      gather_r <= gather_nxt;
    end
  end

endmodule

>>> design/tgarle_fifo.sv
// Two-entry event queue between the packet parser and the image accounting.
module tgarle_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tgarle_pkg::evt_t      push_evt,
  input  logic                  pop,
  output tgarle_pkg::evt_t      head_evt,
  output tgarle_pkg::q_status_t status
);

  tgarle_pkg::evt_t mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       level_r, level_nxt;
  logic             do_push, do_pop;

  assign status.full  = (level_r == 2'd2);
  assign status.empty = (level_r == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_evt     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    level_nxt  = level_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

>>> design/tgarle_back.sv
// Image accounting: count clipping, completion tracking and output register.
module tgarle_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tgarle_pkg::q_status_t           q_status,
  input  tgarle_pkg::evt_t                head_evt,
  output logic                            pop,
  input  logic [tgarle_pkg::AREA_W-1:0]   area,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tgarle_pkg::PIXEL_W-1:0]  out_pixel_value,
  output logic [tgarle_pkg::COUNT_W-1:0]  out_repeat_count,
  output logic                            out_image_done
);

  logic [tgarle_pkg::AREA_W-1:0]  remain_r, remain_nxt;
  logic                           complete_r, complete_nxt;
  logic                           valid_r, valid_nxt;
  logic [tgarle_pkg::PIXEL_W-1:0] pixel_r;
  logic [tgarle_pkg::COUNT_W-1:0] count_r;
  logic                           done_r;

  logic                           silent;
  logic                           load;
  logic [tgarle_pkg::COUNT_W-1:0] clip_count;
  logic [tgarle_pkg::AREA_W-1:0]  remain_sub;

  assign silent = head_evt.is_start || complete_r;
  assign pop    = !q_status.empty && (silent || !valid_r || out_ready);
  assign load   = pop && !silent;

  assign clip_count = ({24'd0, head_evt.count} > remain_r) ?
                      remain_r[tgarle_pkg::COUNT_W-1:0] : head_evt.count;
  assign remain_sub = remain_r - {24'd0, clip_count};

  always_comb begin
    remain_nxt   = remain_r;
    complete_nxt = complete_r;
    valid_nxt    = valid_r && !out_ready;
    if (pop && head_evt.is_start) begin
      remain_nxt   = area;
      complete_nxt = (area == '0);
    end else if (load) begin
      remain_nxt   = remain_sub;
      complete_nxt = (remain_sub == '0);
      valid_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r <= head_evt.pixel;
      count_r <= clip_count;
      done_r  <= (remain_sub == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r   <= tgarle_pkg::AREA_W'(1);
      complete_r <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      remain_r   <= remain_nxt;
      complete_r <= complete_nxt;
      valid_r    <= valid_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_pixel_value  = pixel_r;
  assign out_repeat_count = count_r;
  assign out_image_done   = done_r;

endmodule
